@@ design/assert_macros.svh @@
// Assertion macros used by the tree walker design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/dtlf_pkg.sv @@
// Types and constants of the decision tree leaf finder
package dtlf_pkg;
    localparam int NODES_DEF = 256;
    localparam int FEATURES_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_CAT_DEF = 31;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        REQ_NODE  = 2'd0,
        REQ_FEAT  = 2'd1,
        REQ_COUNT = 2'd2,
        REQ_CLASS = 2'd3
    } t_req;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_SHEN  = 2'd1;
    localparam logic [1:0] CFG_SHF   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         index;
        logic               is_leaf;
        logic [5:0]         split_feature;
        logic signed [31:0] split_threshold;
        logic [31:0]        category_mask;
        logic [7:0]         left_child;
        logic [7:0]         right_child;
        logic signed [31:0] feature_value;
        logic [4:0]         category_count;
        logic [15:0]        sample_tag;
        logic signed [31:0] replacement_value;
    } t_in_word;

    typedef struct packed {
        logic [15:0] result_tag;
        logic [7:0]  leaf_node;
        logic        walk_error;
    } t_out_word;
endpackage

@@ design/dtlf_front.sv @@
// Front end: accepts words, applies table writes, queues classify jobs
module dtlf_front import dtlf_pkg::*; #(
    parameter int NODES = NODES_DEF,
    parameter int FEATURES = FEATURES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_CATEGORIES = MAX_CAT_DEF,
    localparam int NW = $clog2(NODES),
    localparam int FW = $clog2(FEATURES) < 1 ? 1 : $clog2(FEATURES),
    localparam int CW = $clog2(MAX_CATEGORIES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_word,
    input  logic                  i_busy,
    output logic                  o_nd_we,
    output logic [NW-1:0]         o_nd_addr,
    output logic [VALUE_BITS+54:0] o_nd_data,
    output logic                  o_ft_we,
    output logic                  o_ct_we,
    output logic [FW-1:0]         o_ft_addr,
    output logic [VALUE_BITS-1:0] o_ft_data,
    output logic [CW-1:0]         o_ct_data,
    output logic                  o_job_valid,
    input  logic                  i_job_take,
    output logic [15:0]           o_job_tag,
    output logic [VALUE_BITS-1:0] o_job_repl
);
    logic [15:0]           r_tag [QDEPTH];
    logic [VALUE_BITS-1:0] r_repl [QDEPTH];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic                  acc, push;
    logic [VALUE_BITS-1:0] tv;
    logic [4:0]            cc;

    // stall when the job queue is full; hold table writes until every earlier classify word has finished its walk
    assign o_stall = (r_cnt == 2'(QDEPTH)) ||
                     ((i_word.req_type != REQ_CLASS) && ((r_cnt != 2'd0) || i_busy));
    assign acc = i_valid && !o_stall;
    assign push = acc && (i_word.req_type == REQ_CLASS);
    assign tv = VALUE_BITS'(i_word.split_threshold);
    assign cc = (i_word.category_count > 5'(MAX_CATEGORIES)) ? 5'(MAX_CATEGORIES)
              : i_word.category_count;

    assign o_nd_we = acc && (i_word.req_type == REQ_NODE) && (32'(i_word.index) < NODES);
    assign o_nd_addr = NW'(i_word.index);
    assign o_nd_data = {i_word.is_leaf, i_word.split_feature, tv, i_word.category_mask,
                        i_word.left_child, i_word.right_child};
    assign o_ft_addr = FW'(i_word.index);
    assign o_ft_we = acc && (i_word.req_type == REQ_FEAT) && (32'(i_word.index) < FEATURES);
    assign o_ct_we = acc && (i_word.req_type == REQ_COUNT) && (32'(i_word.index) < FEATURES);
    assign o_ft_data = VALUE_BITS'(i_word.feature_value);
    assign o_ct_data = CW'(cc);

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job_tag = r_tag[r_rp];
    assign o_job_repl = r_repl[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_tag[r_wp] <= i_word.sample_tag;
            r_repl[r_wp] <= VALUE_BITS'(i_word.replacement_value);
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_job_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_job_take);
        end
    end
endmodule

@@ design/dtlf_walker.sv @@
// Back end: tree walk over the node memory, one level per pass through the read, feature and evaluate states
module dtlf_walker import dtlf_pkg::*; #(
    parameter int NODES = NODES_DEF,
    parameter int FEATURES = FEATURES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_CATEGORIES = MAX_CAT_DEF,
    localparam int NW = $clog2(NODES),
    localparam int FW = $clog2(FEATURES) < 1 ? 1 : $clog2(FEATURES),
    localparam int CW = $clog2(MAX_CATEGORIES + 1),
    localparam int SW = $clog2(NODES) + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_nd_we,
    input  logic [NW-1:0]         i_nd_addr,
    input  logic [VALUE_BITS+54:0] i_nd_data,
    input  logic                  i_ft_we,
    input  logic                  i_ct_we,
    input  logic [FW-1:0]         i_ft_addr,
    input  logic [VALUE_BITS-1:0] i_ft_data,
    input  logic [CW-1:0]         i_ct_data,
    input  logic [7:0]            i_start,
    input  logic                  i_shen,
    input  logic [5:0]            i_shf,
    input  logic                  i_job_valid,
    output logic                  o_job_take,
    output logic                  o_busy,
    input  logic [15:0]           i_job_tag,
    input  logic [VALUE_BITS-1:0] i_job_repl,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_word
);
    `include "assert_macros.svh"
    typedef enum logic [1:0] {S_IDLE, S_READ, S_FEAT, S_EVAL} t_state;

    logic [VALUE_BITS+54:0] r_nodes [NODES];
    logic [VALUE_BITS-1:0]  r_feat [FEATURES];
    logic [CW-1:0]          r_cnt [FEATURES];
    logic [FEATURES-1:0]    r_cvld;
    logic [VALUE_BITS+54:0] r_nd;
    logic [VALUE_BITS-1:0]  r_fx;
    logic [CW-1:0]          r_fc;
    logic                   r_cv;
    t_state                 r_state;
    logic [NW-1:0]          r_cur;
    logic [SW-1:0]          r_step;
    logic [15:0]            r_tag;
    logic [VALUE_BITS-1:0]  r_repl;
    logic                   r_ov;
    t_out_word              r_ow;

    logic                   n_leaf;
    logic [5:0]             n_f;
    logic signed [VALUE_BITS-1:0] n_th, n_x;
    logic [31:0]            n_mask;
    logic [7:0]             n_l, n_r;
    logic                   n_inr, n_right;
    logic [VALUE_BITS-1:0]  n_cat;
    logic [CW-1:0]          n_cnt;
    logic                   out_free;
    logic                   done;

    assign {n_leaf, n_f, n_th, n_mask, n_l, n_r} = r_nd;
    assign n_inr = 32'(n_f) < FEATURES;
    assign n_cnt = (n_inr && r_cv) ? r_fc : '0;
    assign n_x = (i_shen && n_f == i_shf) ? r_repl : (n_inr ? r_fx : '0);
    assign n_cat = VALUE_BITS'(n_x >>> 16);

    always_comb begin
        if (n_cnt > CW'(1)) begin
            if (n_x[VALUE_BITS-1] || n_cat == '0 || n_cat > VALUE_BITS'(n_cnt))
                n_right = 1'b0;
            else
                n_right = n_mask[n_cat[4:0]];
        end else begin
            n_right = n_x > n_th;
        end
    end

    assign done = n_leaf || (r_step == SW'(NODES - 1));
    assign out_free = !r_ov || !i_stall;
    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign o_busy = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_word = r_ow;

    always_ff @(posedge i_clk) begin
        if (i_nd_we) r_nodes[i_nd_addr] <= i_nd_data;
        if (i_ft_we) r_feat[i_ft_addr] <= i_ft_data;
        if (i_ct_we) r_cnt[i_ft_addr] <= i_ct_data;
        r_nd <= r_nodes[r_cur];
        r_fx <= r_feat[FW'(n_f)];
        r_fc <= r_cnt[FW'(n_f)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld <= '0;
            r_cv <= 1'b0;
        end else begin
            if (i_ct_we) r_cvld[i_ft_addr] <= 1'b1;
            r_cv <= r_cvld[FW'(n_f)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_state == S_EVAL && done && out_free) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_cur <= NW'(i_start);
                        r_step <= '0;
                        r_tag <= i_job_tag;
                        r_repl <= i_job_repl;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_FEAT;
                S_FEAT: r_state <= S_EVAL;
                S_EVAL: begin
                    if (done) begin
                        if (out_free) begin
                            r_ow.result_tag <= r_tag;
                            r_ow.leaf_node <= 8'(r_cur);
                            r_ow.walk_error <= !n_leaf;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_cur <= NW'(n_right ? n_r : n_l);
                        r_step <= r_step + SW'(1);
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_take_starts, i_clk, i_rst_n, o_job_take, r_state == S_READ, "take without walk")
    `ASSERT_IMPL(a_step_bound, i_clk, i_rst_n, r_step <= SW'(NODES - 1), "step overrun")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && i_stall, r_ov && $stable(r_ow), "out lost")
endmodule

@@ design/decision_tree_leaf_finder_top.sv @@
// Decision tree leaf finder: each accepted classify word yields one result word, registered when the walk ends.
// The walker takes a new classify word only once the last walk has ended; a stalled result holds the walk.
// The walk loop reads the node memory once per level, then the feature, and then evaluates the split.
// A two-entry job queue decouples input; write words wait until no walk is queued or running.
// Synchronous active-low reset clears control state, the config registers and the category count valid flags.
module decision_tree_leaf_finder_top import dtlf_pkg::*; #(
    parameter int NODES = NODES_DEF,
    parameter int FEATURES = FEATURES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_CATEGORIES = MAX_CAT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    localparam int NW = $clog2(NODES);
    localparam int FW = $clog2(FEATURES) < 1 ? 1 : $clog2(FEATURES);
    localparam int CW = $clog2(MAX_CATEGORIES + 1);

    logic [7:0] r_start;
    logic       r_shen;
    logic [5:0] r_shf;
    logic nd_we, ft_we, ct_we, jv, jt, wbusy;
    logic [NW-1:0] nd_addr;
    logic [VALUE_BITS+54:0] nd_data;
    logic [FW-1:0] ft_addr;
    logic [VALUE_BITS-1:0] ft_data, jrepl;
    logic [CW-1:0] ct_data;
    logic [15:0] jtag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_shen <= 1'b0;
            r_shf <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START: r_start <= i_cfg_data;
                CFG_SHEN:  r_shen <= i_cfg_data[0];
                CFG_SHF:   r_shf <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    dtlf_front #(.NODES(NODES), .FEATURES(FEATURES), .VALUE_BITS(VALUE_BITS),
                 .MAX_CATEGORIES(MAX_CATEGORIES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word, .i_busy(wbusy),
        .o_nd_we(nd_we), .o_nd_addr(nd_addr), .o_nd_data(nd_data),
        .o_ft_we(ft_we), .o_ct_we(ct_we), .o_ft_addr(ft_addr),
        .o_ft_data(ft_data), .o_ct_data(ct_data),
        .o_job_valid(jv), .i_job_take(jt), .o_job_tag(jtag), .o_job_repl(jrepl));

    dtlf_walker #(.NODES(NODES), .FEATURES(FEATURES), .VALUE_BITS(VALUE_BITS),
                  .MAX_CATEGORIES(MAX_CATEGORIES)) u_walker (
        .i_clk, .i_rst_n,
        .i_nd_we(nd_we), .i_nd_addr(nd_addr), .i_nd_data(nd_data),
        .i_ft_we(ft_we), .i_ct_we(ct_we), .i_ft_addr(ft_addr),
        .i_ft_data(ft_data), .i_ct_data(ct_data),
        .i_start(r_start), .i_shen(r_shen), .i_shf(r_shf),
        .i_job_valid(jv), .o_job_take(jt), .o_busy(wbusy),
        .i_job_tag(jtag), .i_job_repl(jrepl),
        .o_valid, .i_stall, .o_word);
endmodule
